// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the PID controller RTL.
// Each macro expects a clock named clk and an active-high reset named rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pidta_pkg.sv -----
// ---------------------------------------------------------------------------
// pidta_pkg
// Widths, register codes and the command and status bundles shared by the
// controller, the datapath and the divider of the timed PID controller.
// ---------------------------------------------------------------------------
package pidta_pkg;

  // Field widths.
  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 31;
  localparam int TIME_W  = 32;
  localparam int DRIVE_W = 32;
  localparam int INTEG_W = 32;

  // Elapsed time after the gap check fits the largest allowed gap limit.
  localparam int DT_W = 16;

  // Wide accumulator and product register.
  localparam int ACC_W  = 48;
  localparam int PROD_W = 48;

  // Shared multiplier operand widths.
  localparam int MA_W = 34;
  localparam int MB_W = 17;

  // Serial divider: quotient magnitude bits and bits retired per cycle.
  localparam int DIV_QW   = 46;
  localparam int DIV_BITS = 2;

  // Milliseconds per second, the time scale of both the D and the I terms.
  localparam int MS_PER_S = 1000;

  // Default gap limit in milliseconds.
  localparam int MAX_GAP_MS_DEF = 1000;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 2'd3;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_P,   // error * prop_gain
    MUL_D1,  // error difference * deriv_gain
    MUL_D2,  // previous product * 1000
    MUL_I1,  // error * integ_gain
    MUL_I2   // previous product * dt
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;       // take an input word, run the time check
    logic     mul_en;     // register a product
    mul_sel_t mul_sel;
    logic     acc_p;      // accumulator gets the P product
    logic     div_start;
    logic     div_by_dt;  // divisor is dt, otherwise 1000
    logic     d_add;      // add the D quotient, update the previous error
    logic     i_sum;      // integrator plus I quotient
    logic     i_clamp;    // clamp, store and add the integrator
    logic     out_load;   // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic d_en;
    logic i_en;
    logic div_done;
  } status_t;

endpackage

// ----- rtl/pidta_div.sv -----
// ---------------------------------------------------------------------------
// pidta_div
// Signed by unsigned serial divider, truncating toward zero. Works on the
// magnitude two quotient bits per cycle, then restores the sign.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pidta_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pidta_pkg::PROD_W-1:0] dividend,
  input  logic        [pidta_pkg::DT_W-1:0]   divisor,
  output logic                                done,
  output logic signed [pidta_pkg::ACC_W-1:0]  quotient
);

  localparam int QW    = pidta_pkg::DIV_QW;
  localparam int RW    = pidta_pkg::DT_W;
  localparam int NCYC  = pidta_pkg::DIV_QW / pidta_pkg::DIV_BITS;
  localparam int CNT_W = $clog2(NCYC);

  logic                             busy;
  logic                             fix;
  logic [CNT_W-1:0]                 cnt;
  logic                             neg;
  logic [RW-1:0]                    dvs;
  logic [RW-1:0]                    rem;
  logic [QW-1:0]                    quo;
  logic [RW-1:0]                    rem_c;
  logic [QW-1:0]                    quo_c;
  logic [pidta_pkg::PROD_W-1:0]     mag;
  logic signed [pidta_pkg::ACC_W-1:0] q_ext;

  // Dividend magnitude; the quotient fits the lower bits.
  assign mag   = dividend[pidta_pkg::PROD_W-1] ? -dividend : dividend;
  assign q_ext = $signed({{(pidta_pkg::ACC_W-QW){1'b0}}, quo});

  // Restoring steps for one cycle.
  always_comb begin
    logic [RW:0] trial;
    rem_c = rem;
    quo_c = quo;
    for (int i = 0; i < pidta_pkg::DIV_BITS; i++) begin
      trial = {rem_c, quo_c[QW-1]};
      if (trial >= {1'b0, dvs}) begin
        trial = trial - {1'b0, dvs};
        quo_c = {quo_c[QW-2:0], 1'b1};
      end else begin
        quo_c = {quo_c[QW-2:0], 1'b0};
      end
      rem_c = trial[RW-1:0];
    end
  end

  // Sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NCYC - 1)) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[pidta_pkg::PROD_W-1];
      dvs <= divisor;
      rem <= '0;
      quo <= mag[QW-1:0];
    end else if (busy) begin
      rem <= rem_c;
      quo <= quo_c;
    end else if (fix) begin
      quotient <= neg ? -q_ext : q_ext;
    end
  end

  `ASSERT_SAME(a_no_restart, start, !busy && !fix, "divider started while busy")

endmodule

// ----- rtl/pidta_dp.sv -----
// ---------------------------------------------------------------------------
// pidta_dp
// Datapath: configuration registers, loop state, shared multiplier,
// accumulator, integrator clamp, output saturation and the divider.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pidta_dp #(
  parameter int MAX_GAP_MS = pidta_pkg::MAX_GAP_MS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Configuration writes.
  input  logic                                   cfg_we,
  input  logic        [pidta_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pidta_pkg::CFG_DATA_W-1:0] cfg_data,
  // Input word fields.
  input  logic signed [pidta_pkg::ERR_W-1:0]     error_in,
  input  logic        [pidta_pkg::TIME_W-1:0]    now_ms,
  input  logic                                   clear_integ,
  // Controller interface.
  input  pidta_pkg::cmd_t                        cmd,
  output pidta_pkg::status_t                     stat,
  // Result word fields.
  output logic signed [pidta_pkg::DRIVE_W-1:0]   drive,
  output logic                                   integ_reset
);

  localparam int AW = pidta_pkg::ACC_W;

  localparam logic signed [AW-1:0] SAT_HI =
    $signed({{(AW-pidta_pkg::DRIVE_W+1){1'b0}}, {(pidta_pkg::DRIVE_W-1){1'b1}}});
  localparam logic signed [AW-1:0] SAT_LO =
    $signed({{(AW-pidta_pkg::DRIVE_W+1){1'b1}}, {(pidta_pkg::DRIVE_W-1){1'b0}}});

  // Configuration registers.
  logic signed [pidta_pkg::GAIN_W-1:0] kp;
  logic signed [pidta_pkg::GAIN_W-1:0] ki;
  logic signed [pidta_pkg::GAIN_W-1:0] kd;
  logic        [pidta_pkg::LIM_W-1:0]  ilim;

  // Loop state.
  logic        [pidta_pkg::TIME_W-1:0]  prev_time;
  logic                                 prev_valid;
  logic signed [pidta_pkg::ERR_W-1:0]   prev_error;
  logic signed [pidta_pkg::INTEG_W-1:0] integ_acc;

  // Per-word working registers.
  logic signed [pidta_pkg::ERR_W-1:0]  err_q;
  logic        [pidta_pkg::DT_W-1:0]   dt_q;
  logic                                ireset_q;
  logic signed [pidta_pkg::PROD_W-1:0] prod;
  logic signed [AW-1:0]                acc;
  logic signed [AW-1:0]                it_q;

  logic        [pidta_pkg::TIME_W-1:0]  dt_raw;
  logic                                 gap;
  logic signed [pidta_pkg::ERR_W:0]     diff;
  logic signed [pidta_pkg::MA_W-1:0]    ma;
  logic signed [pidta_pkg::MB_W-1:0]    mb;
  logic signed [pidta_pkg::MA_W+pidta_pkg::MB_W-1:0] mp;
  logic signed [AW-1:0]                 lim_s;
  logic signed [AW-1:0]                 clamp_w;
  logic signed [AW-1:0]                 sat_w;
  logic        [pidta_pkg::DT_W-1:0]    div_dvs;
  logic                                 div_done;
  logic signed [AW-1:0]                 div_quo;

  // Elapsed time and the start or long-gap check.
  assign dt_raw = now_ms - prev_time;
  assign gap    = !prev_valid || (dt_raw > pidta_pkg::TIME_W'(MAX_GAP_MS));

  assign diff  = pidta_pkg::ERR_W'(0) + (signed'((pidta_pkg::ERR_W+1)'(err_q))
                 - signed'((pidta_pkg::ERR_W+1)'(prev_error)));
  assign lim_s = $signed({{(AW-pidta_pkg::LIM_W){1'b0}}, ilim});

  // Term enables for the controller.
  assign stat.d_en     = (kd != '0) && (dt_q != '0);
  assign stat.i_en     = (ki != '0) && (dt_q != '0) && (acc < lim_s) && (acc > -lim_s);
  assign stat.div_done = div_done;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_sel)
      pidta_pkg::MUL_P: begin
        ma = pidta_pkg::MA_W'(err_q);
        mb = pidta_pkg::MB_W'(kp);
      end
      pidta_pkg::MUL_D1: begin
        ma = pidta_pkg::MA_W'(diff);
        mb = pidta_pkg::MB_W'(kd);
      end
      pidta_pkg::MUL_D2: begin
        ma = $signed(prod[pidta_pkg::MA_W-1:0]);
        mb = pidta_pkg::MB_W'(pidta_pkg::MS_PER_S);
      end
      pidta_pkg::MUL_I1: begin
        ma = pidta_pkg::MA_W'(err_q);
        mb = pidta_pkg::MB_W'(ki);
      end
      pidta_pkg::MUL_I2: begin
        ma = $signed(prod[pidta_pkg::MA_W-1:0]);
        mb = $signed({1'b0, dt_q});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mp = ma * mb;

  // Integrator clamp to the symmetric limit.
  always_comb begin
    if (it_q > lim_s) begin
      clamp_w = lim_s;
    end else if (it_q < -lim_s) begin
      clamp_w = -lim_s;
    end else begin
      clamp_w = it_q;
    end
  end

  // Output saturation to 32 bits.
  always_comb begin
    if (acc > SAT_HI) begin
      sat_w = SAT_HI;
    end else if (acc < SAT_LO) begin
      sat_w = SAT_LO;
    end else begin
      sat_w = acc;
    end
  end

  // The D term divides by dt, the I term by 1000.
  assign div_dvs = cmd.div_by_dt ? dt_q : pidta_pkg::DT_W'(pidta_pkg::MS_PER_S);

  pidta_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Configuration and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= '0;
      ki         <= '0;
      kd         <= '0;
      ilim       <= '0;
      prev_time  <= '0;
      prev_valid <= 1'b0;
      prev_error <= '0;
      integ_acc  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pidta_pkg::REG_PROP_GAIN:   kp   <= cfg_data[pidta_pkg::GAIN_W-1:0];
          pidta_pkg::REG_INTEG_GAIN:  ki   <= cfg_data[pidta_pkg::GAIN_W-1:0];
          pidta_pkg::REG_DERIV_GAIN:  kd   <= cfg_data[pidta_pkg::GAIN_W-1:0];
          pidta_pkg::REG_INTEG_LIMIT: ilim <= cfg_data[pidta_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        prev_time  <= now_ms;
        prev_valid <= 1'b1;
        if (clear_integ || gap) begin
          integ_acc <= '0;
        end
      end
      if (cmd.d_add) begin
        prev_error <= err_q;
      end
      if (cmd.i_clamp) begin
        integ_acc <= clamp_w[pidta_pkg::INTEG_W-1:0];
      end
    end
  end

  // Per-word working registers and the output register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err_q    <= error_in;
      dt_q     <= gap ? '0 : dt_raw[pidta_pkg::DT_W-1:0];
      ireset_q <= gap;
    end
    if (cmd.mul_en) begin
      prod <= mp[pidta_pkg::PROD_W-1:0];
    end
    if (cmd.acc_p) begin
      acc <= prod;
    end else if (cmd.d_add) begin
      acc <= acc + div_quo;
    end else if (cmd.i_clamp) begin
      acc <= acc + clamp_w;
    end
    if (cmd.i_sum) begin
      it_q <= AW'(integ_acc) + div_quo;
    end
    if (cmd.out_load) begin
      drive       <= sat_w[pidta_pkg::DRIVE_W-1:0];
      integ_reset <= ireset_q;
    end
  end

  `ASSERT_NEXT(a_integ_in_limit, cmd.i_clamp, ($signed(integ_acc) <= $signed({1'b0, ilim})) && ($signed(integ_acc) >= -$signed({1'b0, ilim})), "integrator outside its limit after clamp")

endmodule

// ----- rtl/pidta_ctrl.sv -----
// ---------------------------------------------------------------------------
// pidta_ctrl
// Controller: sequences the P, D and I terms of one input word through the
// datapath and owns the handshakes of both streams.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pidta_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pidta_pkg::status_t   stat,
  output pidta_pkg::cmd_t      cmd
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MP     = 14'b00000000000010,
    S_ACCP   = 14'b00000000000100,
    S_MD1    = 14'b00000000001000,
    S_MD2    = 14'b00000000010000,
    S_DSTART = 14'b00000000100000,
    S_DWAIT  = 14'b00000001000000,
    S_GATE   = 14'b00000010000000,
    S_MI1    = 14'b00000100000000,
    S_MI2    = 14'b00001000000000,
    S_ISTART = 14'b00010000000000,
    S_IWAIT  = 14'b00100000000000,
    S_ICLAMP = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    cmd            = '0;
    cmd.mul_sel    = pidta_pkg::MUL_P;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MP;
        end
      end
      S_MP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidta_pkg::MUL_P;
        state_next  = S_ACCP;
      end
      S_ACCP: begin
        cmd.acc_p  = 1'b1;
        state_next = stat.d_en ? S_MD1 : S_GATE;
      end
      S_MD1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidta_pkg::MUL_D1;
        state_next  = S_MD2;
      end
      S_MD2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidta_pkg::MUL_D2;
        state_next  = S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_by_dt = 1'b1;
        state_next    = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.d_add  = 1'b1;
          state_next = S_GATE;
        end
      end
      S_GATE: begin
        state_next = stat.i_en ? S_MI1 : S_OUT;
      end
      S_MI1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidta_pkg::MUL_I1;
        state_next  = S_MI2;
      end
      S_MI2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = pidta_pkg::MUL_I2;
        state_next  = S_ISTART;
      end
      S_ISTART: begin
        cmd.div_start = 1'b1;
        state_next    = S_IWAIT;
      end
      S_IWAIT: begin
        if (stat.div_done) begin
          cmd.i_sum  = 1'b1;
          state_next = S_ICLAMP;
        end
      end
      S_ICLAMP: begin
        cmd.i_clamp = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free or being drained.
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == S_MP, "accepted word did not start the P term")
  `ASSERT_NEXT(a_result_shown, cmd.out_load, out_valid && (state == S_IDLE), "loaded result not presented")

endmodule

// ----- rtl/pid_timed_antiwindup_top.sv -----
// ---------------------------------------------------------------------------
// pid_timed_antiwindup_top
// Timed PID controller with integrator clamp. Each input word carries a Q8.8
// error, a millisecond timestamp and a clear flag; each produces one Q16.16
// result word, saturated to 32 bits, with a flag when the first sample or a
// gap longer than MAX_GAP_MS reset the integrator. One word is processed at
// a time. A word runs the P term, then the D and the I terms where they are
// enabled; both of these use the shared serial divider, which retires two
// quotient bits per cycle over a 46-bit magnitude. The next word is accepted
// while a result still waits on the output. Configuration writes are always
// ready and belong to idle periods.
// ---------------------------------------------------------------------------

module pid_timed_antiwindup_top #(
  parameter int MAX_GAP_MS = pidta_pkg::MAX_GAP_MS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [47:0]                          s_axis_tdata,  // [15:0] error_in, [47:16] now_ms
  input  logic                                 s_axis_tuser,  // [0] clear_integ
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pidta_pkg::DRIVE_W-1:0]        m_axis_tdata,  // [31:0] drive
  output logic                                 m_axis_tuser,  // [0] integ_reset
  // Configuration writes.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pidta_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pidta_pkg::cmd_t    cmd;
  pidta_pkg::status_t stat;
  logic signed [pidta_pkg::DRIVE_W-1:0] drive;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = drive;

  pidta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pidta_dp #(
    .MAX_GAP_MS (MAX_GAP_MS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .error_in    ($signed(s_axis_tdata[15:0])),
    .now_ms      (s_axis_tdata[47:16]),
    .clear_integ (s_axis_tuser),
    .cmd         (cmd),
    .stat        (stat),
    .drive       (drive),
    .integ_reset (m_axis_tuser)
  );

endmodule
